>>> hdl/rsgm_pkg.sv
// ----------------------------------------------------------------------------
// Range-scan grid marker package
// Shared types, register indexes and constants.
// ----------------------------------------------------------------------------
package rsgm_pkg;

  localparam int unsigned GridWidthDef  = 256;
  localparam int unsigned GridHeightDef = 256;
  localparam logic [7:0]  MarkCost      = 8'd100;
  localparam int unsigned CordicSteps   = 15;
  localparam logic [16:0] CordicGain    = 17'd39797;

  localparam logic [2:0] CfgRangeMin   = 3'd0;
  localparam logic [2:0] CfgRangeMax   = 3'd1;
  localparam logic [2:0] CfgAngleFirst = 3'd2;
  localparam logic [2:0] CfgAngleStep  = 3'd3;
  localparam logic [2:0] CfgOriginX    = 3'd4;
  localparam logic [2:0] CfgOriginY    = 3'd5;
  localparam logic [2:0] CfgCellSize   = 3'd6;
  localparam logic [2:0] CfgClearValue = 3'd7;

  localparam logic [1:0] ModeClear = 2'd0;
  localparam logic [1:0] ModeMark  = 2'd1;

  localparam logic [2:0] StCleared  = 3'd0;
  localparam logic [2:0] StMarked   = 3'd1;
  localparam logic [2:0] StRejected = 3'd2;
  localparam logic [2:0] StOutside  = 3'd3;
  localparam logic [2:0] StRead     = 3'd4;

  typedef struct packed {
    logic [1:0]         mode;
    logic [15:0]        range;
    logic [11:0]        beam_index;
    logic signed [15:0] rot_xx;
    logic signed [15:0] rot_xz;
    logic signed [15:0] rot_zx;
    logic signed [15:0] rot_zz;
    logic signed [23:0] trans_x;
    logic signed [23:0] trans_z;
    logic [7:0]         cell_x;
    logic [7:0]         cell_y;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] hit_x;
    logic [7:0] hit_y;
    logic [7:0] cost;
  } out_item_t;

  function automatic logic [15:0] atan_unit(input logic [3:0] i);
    logic [15:0] v;
    case (i)
      4'd0:    v = 16'd8192;
      4'd1:    v = 16'd4836;
      4'd2:    v = 16'd2555;
      4'd3:    v = 16'd1297;
      4'd4:    v = 16'd651;
      4'd5:    v = 16'd326;
      4'd6:    v = 16'd163;
      4'd7:    v = 16'd81;
      4'd8:    v = 16'd41;
      4'd9:    v = 16'd20;
      4'd10:   v = 16'd10;
      4'd11:   v = 16'd5;
      4'd12:   v = 16'd3;
      4'd13:   v = 16'd1;
      4'd14:   v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

>>> hdl/range_scan_grid_marker_core.sv
// ----------------------------------------------------------------------------
// Range-scan grid marker core
// Occupancy grid of 8-bit costs: clear, mark from a range sample, read.
// ----------------------------------------------------------------------------
// A mark runs 15 CORDIC steps, six products on one multiplier and two 9-bit
//   restoring divisions by cell size; the divisions are skipped when the
//   point falls below the window corner.
// Clear sweeps 2**(XW+YW) cells one per cycle (65536 by default).
// One item at a time; the next item can be taken in the cycle after the result
//   is loaded into the output register, even while that result still waits.
// Reset clears registers to defaults and then sweeps every cell of the grid to
//   zero before the first item is taken.
module range_scan_grid_marker_core #(
  parameter int unsigned GRID_WIDTH  = rsgm_pkg::GridWidthDef,
  parameter int unsigned GRID_HEIGHT = rsgm_pkg::GridHeightDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rsgm_pkg::in_item_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rsgm_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i
);
  import rsgm_pkg::*;

  localparam int unsigned XW    = $clog2(GRID_WIDTH);
  localparam int unsigned YW    = $clog2(GRID_HEIGHT);
  localparam int unsigned AW    = XW + YW;
  localparam int unsigned Depth = 1 << AW;
  // Quotient bits: enough to tell index >= size.
  localparam int unsigned QW    = ((XW > YW) ? XW : YW) + 1;
  localparam int unsigned WW    = 72;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLEAR, S_ANGLE, S_CORDIC, S_MUL, S_WORLD, S_DIV,
    S_READ, S_READ2, S_OUT
  } state_e;

  state_e state_q;
  logic [AW-1:0] addr_q;
  logic [7:0] mem [Depth];
  logic [7:0] rd_q;

  logic [15:0] range_min_q, range_max_q, angle_first_q, angle_step_q, cell_size_q;
  logic [23:0] corner_x_q, corner_y_q;
  logic [7:0]  clear_value_q;

  in_item_t item_q;
  out_item_t res_q;
  out_item_t out_q;
  logic out_valid_q;

  logic [3:0] cnt_q;
  logic signed [16:0] z_q;
  logic neg_q;
  logic signed [18:0] cx_q, cy_q;
  logic signed [35:0] p0_q, p2_q;
  logic signed [WW-1:0] wx_q, wy_q;
  logic [WW-1:0] rem_q;
  logic [QW-1:0] quo_q;
  logic [QW-1:0] mx_q;
  logic div_y_q;

  // Shared multiplier: 36 x 19 signed, one product per cycle.
  logic signed [35:0] mul_a;
  logic signed [18:0] mul_b;
  logic signed [54:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic [AW-1:0] mem_wa;
  logic          mem_we;
  logic [7:0]    mem_wd;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[addr_q];
  end

  assign cfg_ready_o = (state_q == S_IDLE) || (state_q == S_INIT);
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  logic accept;
  assign accept = in_valid_i && !in_stall_o;

  // Combinational helpers
  logic [15:0] ang;
  logic signed [16:0] zf;
  logic fneg;
  logic signed [18:0] dx_s, dy_s;
  logic signed [WW-1:0] unit_w, ox_w, oy_w, dxw, dyw;
  logic [WW-1:0] trial;
  logic [QW+WW-1:0] dsor;

  always_comb begin
    ang  = angle_first_q + 16'(item_q.beam_index) * angle_step_q;
    zf   = 17'(signed'(ang));
    fneg = 1'b0;
    if (zf > 17'sd16384) begin
      zf = zf - 17'sd32768; fneg = 1'b1;
    end else if (zf < -17'sd16384) begin
      zf = zf + 17'sd32768; fneg = 1'b1;
    end
    dx_s   = cy_q >>> cnt_q;
    dy_s   = cx_q >>> cnt_q;
    unit_w = signed'({{(WW-46){1'b0}}, cell_size_q, 30'd0});
    ox_w   = signed'({{(WW-54){corner_x_q[23]}}, corner_x_q, 30'd0});
    oy_w   = signed'({{(WW-54){corner_y_q[23]}}, corner_y_q, 30'd0});
    dxw    = wx_q - ox_w;
    dyw    = wy_q - oy_w;
    dsor   = {{QW{1'b0}}, unit_w} << cnt_q;
    trial  = rem_q - dsor[WW-1:0];
  end

  logic [2:0] step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      addr_q <= '0;
      out_valid_q <= 1'b0;
      range_min_q <= '0; range_max_q <= 16'hFFFF;
      angle_first_q <= 16'hC000; angle_step_q <= 16'd64;
      corner_x_q <= '0; corner_y_q <= '0;
      cell_size_q <= 16'd13; clear_value_q <= '0;
      cnt_q <= '0; step_q <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgRangeMin:   range_min_q   <= cfg_data_i[15:0];
          CfgRangeMax:   range_max_q   <= cfg_data_i[15:0];
          CfgAngleFirst: angle_first_q <= cfg_data_i[15:0];
          CfgAngleStep:  angle_step_q  <= cfg_data_i[15:0];
          CfgOriginX:    corner_x_q    <= cfg_data_i;
          CfgOriginY:    corner_y_q    <= cfg_data_i;
          CfgCellSize:   cell_size_q   <= cfg_data_i[15:0];
          CfgClearValue: clear_value_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      case (state_q)
        S_INIT, S_CLEAR: begin
          addr_q <= addr_q + 1'b1;
          if (addr_q == AW'(Depth - 1)) begin
            addr_q <= '0;
            if (state_q == S_CLEAR) begin
              res_q <= '{status: StCleared, default: '0};
              state_q <= S_OUT;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (accept) begin
            item_q <= in_data_i;
            res_q <= '0;
            if (in_data_i.mode == ModeClear) begin
              addr_q <= '0;
              state_q <= S_CLEAR;
            end else if (in_data_i.mode == ModeMark) begin
              if (in_data_i.range > range_min_q && in_data_i.range < range_max_q) begin
                state_q <= S_ANGLE;
              end else begin
                res_q <= '{status: StRejected, default: '0};
                state_q <= S_OUT;
              end
            end else begin
              addr_q <= AW'((32'(in_data_i.cell_y) << XW) | 32'(in_data_i.cell_x));
              state_q <= S_READ;
            end
          end
        end
        S_ANGLE: begin
          z_q <= zf; neg_q <= fneg;
          cx_q <= 19'(signed'({2'b00, CordicGain}));
          cy_q <= '0; cnt_q <= '0;
          state_q <= S_CORDIC;
        end
        S_CORDIC: begin
          if (z_q >= 0) begin
            cx_q <= cx_q - dx_s; cy_q <= cy_q + dy_s;
            z_q <= z_q - 17'(signed'({1'b0, atan_unit(cnt_q)}));
          end else begin
            cx_q <= cx_q + dx_s; cy_q <= cy_q - dy_s;
            z_q <= z_q + 17'(signed'({1'b0, atan_unit(cnt_q)}));
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 4'(CordicSteps - 1)) begin
            step_q <= '0;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          // Step 0: p2 = r*c. Step 1: p0 = -r*s.
          step_q <= step_q + 1'b1;
          if (step_q == 3'd0) p2_q <= 36'(mul_p);
          else begin
            p0_q <= -36'(mul_p);
            step_q <= '0;
            wx_q <= signed'({{(WW-54){item_q.trans_z[23]}}, item_q.trans_z, 30'd0});
            wy_q <= signed'({{(WW-54){item_q.trans_x[23]}}, item_q.trans_x, 30'd0});
            state_q <= S_WORLD;
          end
        end
        S_WORLD: begin
          step_q <= step_q + 1'b1;
          case (step_q)
            3'd0: wx_q <= wx_q + WW'(mul_p);
            3'd1: wx_q <= wx_q + WW'(mul_p);
            3'd2: wy_q <= wy_q + WW'(mul_p);
            3'd3: wy_q <= wy_q + WW'(mul_p);
            default: begin
              wy_q <= -wy_q;
              state_q <= S_DIV;
              step_q <= '0;
            end
          endcase
        end
        S_DIV: begin
          if (step_q == 3'd0) begin
            if (cell_size_q == '0 || dxw < 0 || dyw < 0) begin
              res_q <= '{status: StOutside, default: '0};
              state_q <= S_OUT;
            end else begin
              rem_q <= unsigned'(dxw); quo_q <= '0;
              cnt_q <= 4'(QW - 1); div_y_q <= 1'b0; step_q <= 3'd1;
            end
          end else begin
            // Restoring division, one quotient bit per cycle; a quotient that
            // overflows QW bits sets all ones, which is out of range anyway.
            if (dsor[QW+WW-1:WW] == '0 && rem_q >= dsor[WW-1:0]) begin
              rem_q <= trial;
              quo_q[cnt_q[$clog2(QW)-1:0]] <= 1'b1;
            end
            if (cnt_q == '0) begin
              if (!div_y_q) begin
                mx_q <= quo_q | (QW'(dsor[QW+WW-1:WW] == '0 && rem_q >= dsor[WW-1:0]));
                rem_q <= unsigned'(dyw); quo_q <= '0;
                cnt_q <= 4'(QW - 1); div_y_q <= 1'b1;
                if (unsigned'(dxw) >= (WW'(unit_w) << QW)) mx_q <= '1;
              end else begin
                step_q <= 3'd2;
                quo_q <= quo_q | (QW'(dsor[QW+WW-1:WW] == '0 && rem_q >= dsor[WW-1:0]));
                if (unsigned'(dyw) >= (WW'(unit_w) << QW)) quo_q <= '1;
                state_q <= S_READ2;
              end
            end else begin
              cnt_q <= cnt_q - 1'b1;
            end
          end
        end
        S_READ2: begin
          if (32'(mx_q) >= GRID_WIDTH || 32'(quo_q) >= GRID_HEIGHT) begin
            res_q <= '{status: StOutside, default: '0};
          end else begin
            addr_q <= AW'((32'(quo_q) << XW) | 32'(mx_q));
            res_q <= '{status: StMarked, hit_x: 8'(mx_q), hit_y: 8'(quo_q),
                       cost: MarkCost};
          end
          step_q <= '0;
          state_q <= S_OUT;
        end
        S_READ: begin
          step_q <= step_q + 1'b1;
          if (step_q == 3'd1) begin
            step_q <= '0;
            res_q <= '{status: StRead, hit_x: item_q.cell_x, hit_y: item_q.cell_y,
                       cost: (32'(item_q.cell_x) < GRID_WIDTH &&
                              32'(item_q.cell_y) < GRID_HEIGHT) ? rd_q : 8'd0};
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          // Wait here while the previous result is still held by the receiver.
          if (!out_valid_q || !out_stall_i) begin
            out_q <= res_q;
            out_valid_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Multiplier operand selection and grid write control.
  always_comb begin
    mul_a = 36'(signed'({1'b0, item_q.range}));
    mul_b = neg_q ? -cx_q : cx_q;
    mem_we = 1'b0; mem_wa = addr_q; mem_wd = 8'd0;
    case (state_q)
      S_MUL: mul_b = (step_q == 3'd0) ? (neg_q ? -cx_q : cx_q) : (neg_q ? -cy_q : cy_q);
      S_WORLD: begin
        case (step_q)
          3'd0: begin mul_a = p0_q; mul_b = 19'(item_q.rot_zx); end
          3'd1: begin mul_a = p2_q; mul_b = 19'(item_q.rot_zz); end
          3'd2: begin mul_a = p0_q; mul_b = 19'(item_q.rot_xx); end
          3'd3: begin mul_a = p2_q; mul_b = 19'(item_q.rot_xz); end
          default: ;
        endcase
      end
      S_INIT: mem_we = 1'b1;
      S_CLEAR: begin mem_we = 1'b1; mem_wd = clear_value_q; end
      S_OUT: begin
        mem_we = (res_q.status == StMarked) && (!out_valid_q || !out_stall_i);
        mem_wd = MarkCost;
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o)
    else $error("input taken while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |=> out_valid_q)
    else $error("result not presented");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled result changed");

endmodule

>>> verif/rsgm_grid_checker.sv
// ----------------------------------------------------------------------------
// Range-scan grid marker checker
// Watches the item, result and register channels, keeps its own copy of the
// cost grid and the registers, predicts every result and compares it.
// ----------------------------------------------------------------------------
module rsgm_grid_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  rsgm_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  rsgm_pkg::out_item_t out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [23:0]         cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import rsgm_pkg::*;

  localparam longint Q30 = longint'(1) << 30;
  localparam int Width = GridWidthDef;
  localparam int Height = GridHeightDef;

  logic [7:0]         cost_map [Width*Height];
  logic [15:0]        range_lo = 16'd0;
  logic [15:0]        range_hi = 16'hFFFF;
  logic [15:0]        angle_zero = 16'hC000;
  logic [15:0]        angle_inc = 16'd64;
  logic signed [23:0] corner_x = '0;
  logic signed [23:0] corner_y = '0;
  logic [15:0]        cell_edge = 16'd13;
  logic [7:0]         fill_cost = 8'd0;
  out_item_t          pending_reports[$];
  int                 mismatches = 0;

  int atan_step [CordicSteps] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20,
                                  10, 5, 3, 1, 1};

  initial begin
    foreach (cost_map[k]) cost_map[k] = 8'd0;
  end

  assign fail_count_o = mismatches;
  assign pending_o    = pending_reports.size();

  // Sine and cosine of a binary angle, Q.16, by rotation steps.
  task automatic beam_trig(input logic [15:0] ang, output longint c, output longint s);
    int     z;
    bit     flip;
    longint x, y, sx, sy;
    z = int'(signed'(ang));
    flip = 1'b0;
    x = longint'(CordicGain);
    y = 0;
    if (z > 16384) begin
      z -= 32768;
      flip = 1'b1;
    end else if (z < -16384) begin
      z += 32768;
      flip = 1'b1;
    end
    for (int i = 0; i < CordicSteps; i++) begin
      sx = y >>> i;
      sy = x >>> i;
      if (z >= 0) begin
        x -= sx; y += sy; z -= atan_step[i];
      end else begin
        x += sx; y -= sy; z += atan_step[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  // Applies one grid operation to the local grid and returns its report.
  task automatic apply_grid_op(input in_item_t it, output out_item_t rep);
    logic [15:0] ang;
    longint      c, s, p0, p2, wx, wy, dx, dy, unit, mx, my;
    rep = '0;
    if (it.mode == ModeClear) begin
      foreach (cost_map[k]) cost_map[k] = fill_cost;
      rep.status = StCleared;
    end else if (it.mode == ModeMark) begin
      if (!(it.range > range_lo && it.range < range_hi)) begin
        rep.status = StRejected;
      end else begin
        ang = angle_zero + 16'(it.beam_index * angle_inc);
        beam_trig(ang, c, s);
        p2 = longint'(it.range) * c;
        p0 = -(longint'(it.range) * s);
        wx = longint'(it.rot_zx) * p0 + longint'(it.rot_zz) * p2 + longint'(it.trans_z) * Q30;
        wy = -(longint'(it.rot_xx) * p0 + longint'(it.rot_xz) * p2
               + longint'(it.trans_x) * Q30);
        dx = wx - longint'(corner_x) * Q30;
        dy = wy - longint'(corner_y) * Q30;
        unit = longint'(cell_edge) * Q30;
        if (unit <= 0 || dx < 0 || dy < 0) begin
          rep.status = StOutside;
        end else begin
          mx = dx / unit;
          my = dy / unit;
          if (mx >= Width || my >= Height) begin
            rep.status = StOutside;
          end else begin
            cost_map[my * Width + mx] = MarkCost;
            rep.status = StMarked;
            rep.hit_x  = mx[7:0];
            rep.hit_y  = my[7:0];
            rep.cost   = MarkCost;
          end
        end
      end
    end else begin
      // Both remaining mode codes read a cell.
      rep.status = StRead;
      rep.hit_x  = it.cell_x;
      rep.hit_y  = it.cell_y;
      rep.cost   = cost_map[int'(it.cell_y) * Width + int'(it.cell_x)];
    end
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgRangeMin:   range_lo   = cfg_data_i[15:0];
          CfgRangeMax:   range_hi   = cfg_data_i[15:0];
          CfgAngleFirst: angle_zero = cfg_data_i[15:0];
          CfgAngleStep:  angle_inc  = cfg_data_i[15:0];
          CfgOriginX:    corner_x   = cfg_data_i;
          CfgOriginY:    corner_y   = cfg_data_i;
          CfgCellSize:   cell_edge  = cfg_data_i[15:0];
          CfgClearValue: fill_cost  = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (pending_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result %p", $realtime, out_data_i);
        end else begin
          want = pending_reports.pop_front();
          if (want.status !== out_data_i.status || want.hit_x !== out_data_i.hit_x ||
              want.hit_y !== out_data_i.hit_y || want.cost !== out_data_i.cost) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: result mismatch, expected %p, got %p",
                       $realtime, want, out_data_i);
          end
        end
      end
      // The item is taken after the result check, so a same-cycle result
      // always belongs to an earlier item.
      if (in_valid_i && !in_stall_i) begin
        apply_grid_op(in_data_i, want);
        pending_reports.push_back(want);
      end
    end
  end

endmodule

>>> verif/range_scan_grid_marker_core_test.sv
// ----------------------------------------------------------------------------
// Range-scan grid marker testbench
// Directed clears, marks and reads at the field extremes, then random phases
// of mostly well-formed range samples under several register, idle and
// stall settings. A checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module range_scan_grid_marker_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rsgm_pkg::*;

  localparam logic [1:0] ModeRead  = 2'd2;
  localparam logic [1:0] ModeRead3 = 2'd3;
  localparam int StallLimit = 500000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [2:0]  cfg_index = CfgRangeMin;
  logic [23:0] cfg_data = '0;
  int        fail_count, pending;
  int        idle_pct = 0;
  int        stall_pct = 0;
  int        quiet_cycles = 0;

  range_scan_grid_marker_core DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  rsgm_grid_checker grid_check (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_item(input in_item_t it);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Writes all eight registers in one burst; the block must be idle.
  task automatic load_settings(input logic [15:0] rmin, input logic [15:0] rmax,
                               input logic [15:0] afirst, input logic [15:0] astep,
                               input logic [23:0] ox, input logic [23:0] oy,
                               input logic [15:0] cs, input logic [7:0] cv);
    logic [23:0] vals [8];
    vals = '{24'(rmin), 24'(rmax), 24'(afirst), 24'(astep), ox, oy, 24'(cs), 24'(cv)};
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t sample_item(input logic [15:0] rng, input logic [11:0] beam,
                                           input int rot_q, input int tx, input int tz);
    in_item_t it;
    it = '0;
    it.mode = ModeMark;
    it.range = rng;
    it.beam_index = beam;
    // Pose rotations in quarter turns keep the point near the translation.
    case (rot_q & 3)
      0: begin it.rot_xx = 16'sd16384;  it.rot_zz = 16'sd16384;  end
      1: begin it.rot_xz = 16'sd16384;  it.rot_zx = -16'sd16384; end
      2: begin it.rot_xx = -16'sd16384; it.rot_zz = -16'sd16384; end
      default: begin it.rot_xz = -16'sd16384; it.rot_zx = 16'sd16384; end
    endcase
    it.trans_x = 24'(tx);
    it.trans_z = 24'(tz);
    return it;
  endfunction

  function automatic in_item_t read_item(input int cx, input int cy);
    in_item_t it;
    it = '0;
    it.mode = ($urandom_range(9) == 0) ? ModeRead3 : ModeRead;
    it.cell_x = 8'(cx);
    it.cell_y = 8'(cy);
    return it;
  endfunction

  function automatic in_item_t noise_item();
    in_item_t it;
    it.mode = 2'($urandom_range(3, 1));
    it.range = 16'($urandom);
    it.beam_index = 12'($urandom);
    it.rot_xx = 16'($urandom_range(32768) - 16384);
    it.rot_xz = 16'($urandom_range(32768) - 16384);
    it.rot_zx = 16'($urandom_range(32768) - 16384);
    it.rot_zz = 16'($urandom_range(32768) - 16384);
    it.trans_x = 24'($urandom);
    it.trans_z = 24'($urandom);
    it.cell_x = 8'($urandom);
    it.cell_y = 8'($urandom);
    return it;
  endfunction

  initial begin
    in_item_t it;
    int cell_c, span, ctr, rspan;
    int p_cs [5];
    int p_ctr [5];
    int p_rsp [5];
    p_cs  = '{13, 256, 64, 65535, 1};
    p_ctr = '{1638, 1024, 0, 0, 0};
    p_rsp = '{1500, 768, 1000, 3000, 2000};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: one-meter cells, quarter turn per beam.
    load_settings(16'd16, 16'd4096, 16'd0, 16'd16384, 24'd0, 24'd0, 16'd256, 8'd255);
    it = '0;
    send_item(it);
    send_item(read_item(0, 0));
    send_item(read_item(255, 255));
    for (int b = 0; b < 4; b++) send_item(sample_item(16'd512, 12'(b), b, -2048, 2048));
    send_item(sample_item(16'd16, 12'd0, 0, -2048, 2048));
    send_item(sample_item(16'd4096, 12'd0, 0, -2048, 2048));
    send_item(sample_item(16'd0, 12'd0, 0, -2048, 2048));
    send_item(sample_item(16'hFFFF, 12'd0, 0, -2048, 2048));
    send_item(sample_item(16'd17, 12'd4095, 3, -2048, 2048));
    send_item(sample_item(16'd4095, 12'd2, 1, -2048, 2048));
    send_item(sample_item(16'd300, 12'd0, 0, -2048, -8388608));
    send_item(sample_item(16'd300, 12'd0, 0, 8388607, 2048));
    send_item(sample_item(16'd300, 12'd0, 0, -8388608, 8388607));
    send_item(read_item(8, 6));
    send_item(read_item(10, 8));
    send_item(read_item(6, 10));
    drain_results();
    // Zero cell size and angle wrap extremes.
    load_settings(16'd0, 16'hFFFF, 16'h8000, 16'hFFFF, 24'd0, 24'd0, 16'd0, 8'd0);
    send_item(sample_item(16'd512, 12'd4095, 0, -2048, 2048));
    send_item(sample_item(16'd512, 12'd1, 2, -2048, 2048));
    drain_results();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 57; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 57; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase
      case (ph)
        0: load_settings(16'd0, 16'hFFFF, 16'hC000, 16'd64, 24'd0, 24'd0, 16'd13, 8'd0);
        1: load_settings(16'd16, 16'd700, 16'd0, 16'd1, 24'd0, 24'd0, 16'd256, 8'd3);
        2: load_settings(16'd0, 16'hFFFF, 16'h7FFF, 16'hFFFF, -24'sd1280, -24'sd1280,
                         16'd64, 8'd255);
        3: load_settings(16'd0, 16'hFFFF, 16'd0, 16'd4096, 24'h800000, 24'h800000,
                         16'hFFFF, 8'd1);
        default: load_settings(16'hFFFF, 16'd0, 16'h8000, 16'd0, 24'h7FFFFF, 24'h7FFFFF,
                               16'd1, 8'd77);
      endcase
      ctr = p_ctr[ph];
      rspan = p_rsp[ph];
      cell_c = (ph == 2) ? 80 : (ph == 3 ? 128 : ctr / p_cs[ph]);
      span = rspan / p_cs[ph] + 2;
      it = '0;
      send_item(it);
      for (int n = 0; n < 100; n++) begin
        if (ph == 1 && n == 50) drain_results();
        case ($urandom_range(19))
          0, 1, 2: send_item(noise_item());
          3, 4, 5, 6:
            send_item(read_item(
              $urandom_range((cell_c + span > 255) ? 255 : cell_c + span,
                             (cell_c - span < 0) ? 0 : cell_c - span),
              $urandom_range((cell_c + span > 255) ? 255 : cell_c + span,
                             (cell_c - span < 0) ? 0 : cell_c - span)));
          default:
            send_item(sample_item(16'($urandom_range(rspan)), 12'($urandom),
                                  $urandom_range(3), -ctr, ctr));
        endcase
      end
      drain_results();
    end

    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
